>>> rtl/core/minmod_slope_reconstruction_unit_macros.svh
// Assertion macros shared by the minmod slope reconstruction RTL.
`ifndef MINMOD_SLOPE_RECONSTRUCTION_UNIT_MACROS_SVH
`define MINMOD_SLOPE_RECONSTRUCTION_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define MSRU_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

`define MSRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequence missing in next cycle");

`else

`define MSRU_ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`define MSRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/msru_pkg.sv
// Types and constants of the minmod slope reconstruction unit.
package msru_pkg;

    localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;
    localparam logic        [31:0] SAT_MAX_U = 32'h7FFF_FFFF;
    localparam logic        [33:0] OFF_CAP   = 34'h2_0000_0000;
    localparam logic        [63:0] ROOT_BIT0 = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] pressure;
        logic signed [31:0] velocity;
        logic signed [31:0] left_edge;
        logic signed [31:0] right_edge;
        logic               frame_end;
    } t_item;

    typedef struct packed {
        logic signed [31:0] left_face_density;
        logic signed [31:0] left_face_pressure;
        logic signed [31:0] left_face_velocity;
        logic signed [31:0] right_face_density;
        logic signed [31:0] right_face_pressure;
        logic signed [31:0] right_face_velocity;
        logic               grid_done;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CV_SQ,
        S_CV_ROOT,
        S_CV_DIV,
        S_SL_DIV,
        S_LIM_MUL,
        S_DONE
    } t_state;

endpackage

>>> rtl/core/msru_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module msru_div #(
    parameter int DW = 50,
    parameter int VW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_quo, n_quo;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_dvs, n_dvs;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    always_comb begin
        trial  = {r_rem, r_quo[DW-1]};
        diff   = trial - {1'b0, r_dvs};
        ge     = (trial >= {1'b0, r_dvs});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[VW-1:0] : trial[VW-1:0];
            n_quo = {r_quo[DW-2:0], ge};
            if (r_cnt == CW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/core/msru_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module msru_mul #(
    parameter int AW = 50,
    parameter int BW = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_product
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_a, n_a;
    logic [BW-1:0] r_b, n_b;
    logic [AW:0]   sum;

    always_comb begin
        sum    = {1'b0, r_acc[PW-1 -: AW]} + (r_b[0] ? {1'b0, r_a} : '0);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
        end else if (r_busy) begin
            n_acc = {sum, r_acc[BW-1:1]};
            n_b   = r_b >> 1;
            if (r_cnt == CW'(BW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

>>> rtl/core/minmod_slope_reconstruction_unit.sv
// Top level of the minmod slope reconstruction unit on a non-uniform 1D grid.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   cells    | i_in_valid, o_in_ready, i_in_data    | in
//   faces    | o_out_valid, i_out_ready, o_out_data | out
//   config   | i_cfg_wr_en, i_cfg_wr_data           | in
//
// A cell that only fills the window is taken in without starting a computation. A cell that
// completes a window runs nine passes of the bit-serial divider and three of the bit-serial
// multiplier; a slope with zero difference or zero spacing skips its division. Relativistic
// mode adds the square, root and division of each velocity conversion. Reset is synchronous
// and clears the control state and the window. A finished result waits in the output
// register while the next cell is taken in.
`include "minmod_slope_reconstruction_unit_macros.svh"

module minmod_slope_reconstruction_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  msru_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output msru_pkg::t_result o_out_data
);
    import msru_pkg::*;

    localparam int QW = FRAC_BITS + 34;
    localparam int VW = 34;
    localparam int BW = 33;
    localparam int PW = QW + BW;
    localparam logic [31:0]   ONE      = 32'd1 << FRAC_BITS;
    localparam logic [63:0]   ONE_SQ   = 64'd1 << (2 * FRAC_BITS);
    localparam logic [PW-1:0] PROD_CAP = {{(PW-1){1'b0}}, 1'b1} << (33 + FRAC_BITS);

    t_state             r_state, n_state;
    logic               r_issued, n_issued;
    logic [1:0]         r_fill, n_fill;
    logic               r_rel, n_rel;
    logic               r_last, n_last;
    logic signed [31:0] r_win_d [2], n_win_d [2];
    logic signed [31:0] r_win_p [2], n_win_p [2];
    logic signed [31:0] r_win_v [2], n_win_v [2];
    logic signed [31:0] r_win_le [2], n_win_le [2];
    logic signed [31:0] r_win_re [2], n_win_re [2];
    logic signed [31:0] r_val [3][3], n_val [3][3];
    logic signed [31:0] r_edge [4], n_edge [4];
    logic [1:0]         r_var, n_var;
    logic [1:0]         r_j, n_j;
    logic [1:0]         r_cv_idx, n_cv_idx;
    logic               r_cv_back, n_cv_back;
    logic [31:0]        r_cv_m, n_cv_m;
    logic               r_cv_neg, n_cv_neg;
    logic [63:0]        r_sq_x, n_sq_x;
    logic [63:0]        r_sq_res, n_sq_res;
    logic [63:0]        r_sq_bit, n_sq_bit;
    logic [QW-1:0]      r_sl_mag [3], n_sl_mag [3];
    logic               r_sl_neg [3], n_sl_neg [3];
    logic               r_pend_neg, n_pend_neg;
    logic               r_off_neg, n_off_neg;
    logic signed [31:0] r_lf [3], n_lf [3];
    logic signed [31:0] r_rf [3], n_rf [3];
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               in_acc;
    logic               out_acc;
    logic               div_start, div_done;
    logic [QW-1:0]      div_dnd, div_quo;
    logic [VW-1:0]      div_dvs;
    logic               mul_start, mul_done;
    logic [QW-1:0]      mul_a;
    logic [BW-1:0]      mul_b;
    logic [PW-1:0]      mul_prod;
    logic signed [31:0] cv_src;
    logic [31:0]        cv_mag;
    logic               cv_wr;
    logic signed [31:0] cv_res;
    logic signed [31:0] qc;
    logic [63:0]        sq_try;
    logic signed [34:0] sl_num, sl_den;
    logic [34:0]        num_mag, den_mag;
    logic               sl_next;
    logic               lim_ok;
    logic [QW-1:0]      lim_mag;
    logic signed [32:0] w;
    logic [BW-1:0]      w_mag;
    logic [33:0]        off_mag;
    logic signed [35:0] off_s, sum_l, sum_r, c_ext;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [31:0] y;
        if (x > 36'(SAT_MAX)) begin
            y = SAT_MAX;
        end else if (x < 36'(SAT_MIN)) begin
            y = SAT_MIN;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = r_out_valid && i_out_ready;

    always_comb begin
        cv_src = r_cv_back ? (r_cv_idx[0] ? r_rf[2] : r_lf[2]) : r_val[2][r_cv_idx];
        cv_mag = cv_src[31] ? (32'd0 - cv_src) : cv_src;
        sq_try = r_sq_res + r_sq_bit;

        case (r_j)
            2'd0: begin
                sl_num = 35'(r_val[0][1]) - 35'(r_val[0][0]);
                sl_den = 35'(r_edge[2]) - 35'(r_edge[0]);
            end
            2'd1: begin
                sl_num = 35'(r_val[0][2]) - 35'(r_val[0][1]);
                sl_den = 35'(r_edge[3]) - 35'(r_edge[1]);
            end
            default: begin
                sl_num = 35'(r_val[0][2]) - 35'(r_val[0][0]);
                sl_den = 35'(r_edge[3]) + 35'(r_edge[2]) - 35'(r_edge[0]) - 35'(r_edge[1]);
            end
        endcase
        num_mag = sl_num[34] ? 35'(-sl_num) : 35'(sl_num);
        den_mag = sl_den[34] ? 35'(-sl_den) : 35'(sl_den);

        lim_ok  = !(r_sl_mag[0] != '0 && r_sl_mag[1] != '0 && r_sl_neg[0] != r_sl_neg[1]);
        lim_mag = r_sl_mag[0];
        if (r_sl_mag[1] < lim_mag) begin
            lim_mag = r_sl_mag[1];
        end
        if (r_sl_mag[2] < lim_mag) begin
            lim_mag = r_sl_mag[2];
        end
        if (!lim_ok) begin
            lim_mag = '0;
        end
        w     = 33'(r_edge[2]) - 33'(r_edge[1]);
        w_mag = w[32] ? BW'(-w) : BW'(w);

        off_mag = (mul_prod >= PROD_CAP) ? OFF_CAP : 34'(mul_prod >> (FRAC_BITS + 1));
        off_s   = r_off_neg ? -36'(off_mag) : 36'(off_mag);
        c_ext   = 36'(r_val[0][1]);
        sum_l   = c_ext - off_s;
        sum_r   = c_ext + off_s;

        qc = (div_quo > QW'(SAT_MAX_U)) ? SAT_MAX : div_quo[31:0];

        div_dnd = (r_state == S_SL_DIV) ? (QW'(num_mag) << (FRAC_BITS + 1))
                                        : (QW'(r_cv_m) << FRAC_BITS);
        div_dvs = (r_state == S_SL_DIV) ? den_mag[VW-1:0] : r_sq_res[VW-1:0];
        mul_a   = (r_state == S_LIM_MUL) ? lim_mag : QW'(cv_mag);
        mul_b   = (r_state == S_LIM_MUL) ? w_mag : BW'(cv_mag);
    end

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_fill      = r_fill;
        n_rel       = r_rel;
        n_last      = r_last;
        n_win_d     = r_win_d;
        n_win_p     = r_win_p;
        n_win_v     = r_win_v;
        n_win_le    = r_win_le;
        n_win_re    = r_win_re;
        n_val       = r_val;
        n_edge      = r_edge;
        n_var       = r_var;
        n_j         = r_j;
        n_cv_idx    = r_cv_idx;
        n_cv_back   = r_cv_back;
        n_cv_m      = r_cv_m;
        n_cv_neg    = r_cv_neg;
        n_sq_x      = r_sq_x;
        n_sq_res    = r_sq_res;
        n_sq_bit    = r_sq_bit;
        n_sl_mag    = r_sl_mag;
        n_sl_neg    = r_sl_neg;
        n_pend_neg  = r_pend_neg;
        n_off_neg   = r_off_neg;
        n_lf        = r_lf;
        n_rf        = r_rf;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;
        mul_start   = 1'b0;
        cv_wr       = 1'b0;
        cv_res      = '0;
        sl_next     = 1'b0;
        o_in_ready  = (r_state == S_IDLE);

        if (i_cfg_wr_en) begin
            n_rel = i_cfg_wr_data;
        end
        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val[0][0] = r_win_d[0];
                    n_val[0][1] = r_win_d[1];
                    n_val[0][2] = i_in_data.density;
                    n_val[1][0] = r_win_p[0];
                    n_val[1][1] = r_win_p[1];
                    n_val[1][2] = i_in_data.pressure;
                    n_val[2][0] = r_win_v[0];
                    n_val[2][1] = r_win_v[1];
                    n_val[2][2] = i_in_data.velocity;
                    n_edge[0]   = r_win_le[0];
                    n_edge[1]   = r_win_le[1];
                    n_edge[2]   = r_win_re[1];
                    n_edge[3]   = i_in_data.right_edge;
                    n_last      = i_in_data.frame_end;
                    n_win_d     = '{r_win_d[1], i_in_data.density};
                    n_win_p     = '{r_win_p[1], i_in_data.pressure};
                    n_win_v     = '{r_win_v[1], i_in_data.velocity};
                    n_win_le    = '{r_win_le[1], i_in_data.left_edge};
                    n_win_re    = '{r_win_re[1], i_in_data.right_edge};
                    if (i_in_data.frame_end) begin
                        n_fill = 2'd0;
                    end else if (r_fill != 2'd2) begin
                        n_fill = r_fill + 2'd1;
                    end
                    if (r_fill == 2'd2) begin
                        n_var     = 2'd0;
                        n_j       = 2'd0;
                        n_cv_idx  = 2'd0;
                        n_cv_back = 1'b0;
                        n_issued  = 1'b0;
                        n_state   = r_rel ? S_CV_SQ : S_SL_DIV;
                    end
                end
            end
            S_CV_SQ: begin
                if (!r_issued) begin
                    n_cv_m   = cv_mag;
                    n_cv_neg = cv_src[31];
                    if (!r_cv_back && cv_mag >= ONE) begin
                        cv_wr  = 1'b1;
                        cv_res = cv_src[31] ? -SAT_MAX : SAT_MAX;
                    end else begin
                        mul_start = 1'b1;
                        n_issued  = 1'b1;
                    end
                end else if (mul_done) begin
                    n_sq_x   = r_cv_back ? (ONE_SQ + mul_prod[63:0]) : (ONE_SQ - mul_prod[63:0]);
                    n_sq_res = '0;
                    n_sq_bit = ROOT_BIT0;
                    n_issued = 1'b0;
                    n_state  = S_CV_ROOT;
                end
            end
            S_CV_ROOT: begin
                if (r_sq_bit == '0) begin
                    if (r_sq_res == '0) begin
                        cv_wr  = 1'b1;
                        cv_res = r_cv_back ? '0 : (r_cv_neg ? -SAT_MAX : SAT_MAX);
                    end else begin
                        n_state = S_CV_DIV;
                    end
                end else begin
                    if (r_sq_x >= sq_try) begin
                        n_sq_x   = r_sq_x - sq_try;
                        n_sq_res = (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        n_sq_res = r_sq_res >> 1;
                    end
                    n_sq_bit = r_sq_bit >> 2;
                end
            end
            S_CV_DIV: begin
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (div_done) begin
                    cv_wr = 1'b1;
                    if (r_cv_back) begin
                        cv_res = r_cv_neg ? -div_quo[31:0] : div_quo[31:0];
                    end else begin
                        cv_res = r_cv_neg ? -qc : qc;
                    end
                end
            end
            S_SL_DIV: begin
                if (!r_issued) begin
                    if (sl_num == '0 || sl_den == '0) begin
                        n_sl_mag[r_j] = '0;
                        n_sl_neg[r_j] = 1'b0;
                        sl_next       = 1'b1;
                    end else begin
                        div_start  = 1'b1;
                        n_issued   = 1'b1;
                        n_pend_neg = sl_num[34] ^ sl_den[34];
                    end
                end else if (div_done) begin
                    n_sl_mag[r_j] = div_quo;
                    n_sl_neg[r_j] = r_pend_neg && (div_quo != '0);
                    n_issued      = 1'b0;
                    sl_next       = 1'b1;
                end
                if (sl_next) begin
                    if (r_j == 2'd2) begin
                        n_j     = 2'd0;
                        n_state = S_LIM_MUL;
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end
            end
            S_LIM_MUL: begin
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued  = 1'b1;
                    n_off_neg = (r_sl_neg[0] && (lim_mag != '0)) != w[32];
                end else if (mul_done) begin
                    n_lf     = '{r_lf[1], r_lf[2], sat32(sum_l)};
                    n_rf     = '{r_rf[1], r_rf[2], sat32(sum_r)};
                    n_val    = '{r_val[1], r_val[2], r_val[0]};
                    n_issued = 1'b0;
                    if (r_var == 2'd2) begin
                        n_var     = 2'd0;
                        n_cv_idx  = 2'd0;
                        n_cv_back = 1'b1;
                        n_state   = r_rel ? S_CV_SQ : S_DONE;
                    end else begin
                        n_var   = r_var + 2'd1;
                        n_state = S_SL_DIV;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || out_acc) begin
                    n_out.left_face_density   = r_lf[0];
                    n_out.left_face_pressure  = r_lf[1];
                    n_out.left_face_velocity  = r_lf[2];
                    n_out.right_face_density  = r_rf[0];
                    n_out.right_face_pressure = r_rf[1];
                    n_out.right_face_velocity = r_rf[2];
                    n_out.grid_done           = r_last;
                    n_out_valid               = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cv_wr) begin
            if (r_cv_back) begin
                if (r_cv_idx[0]) begin
                    n_rf[2] = cv_res;
                end else begin
                    n_lf[2] = cv_res;
                end
            end else begin
                n_val[2][r_cv_idx] = cv_res;
            end
            n_issued = 1'b0;
            if (r_cv_idx == (r_cv_back ? 2'd1 : 2'd2)) begin
                n_cv_idx = 2'd0;
                n_state  = r_cv_back ? S_DONE : S_SL_DIV;
            end else begin
                n_cv_idx = r_cv_idx + 2'd1;
                n_state  = S_CV_SQ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_fill      <= 2'd0;
            r_rel       <= 1'b0;
            r_out_valid <= 1'b0;
            r_win_d     <= '{default: '0};
            r_win_p     <= '{default: '0};
            r_win_v     <= '{default: '0};
            r_win_le    <= '{default: '0};
            r_win_re    <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_fill      <= n_fill;
            r_rel       <= n_rel;
            r_out_valid <= n_out_valid;
            r_win_d     <= n_win_d;
            r_win_p     <= n_win_p;
            r_win_v     <= n_win_v;
            r_win_le    <= n_win_le;
            r_win_re    <= n_win_re;
        end
        r_last     <= n_last;
        r_val      <= n_val;
        r_edge     <= n_edge;
        r_var      <= n_var;
        r_j        <= n_j;
        r_cv_idx   <= n_cv_idx;
        r_cv_back  <= n_cv_back;
        r_cv_m     <= n_cv_m;
        r_cv_neg   <= n_cv_neg;
        r_sq_x     <= n_sq_x;
        r_sq_res   <= n_sq_res;
        r_sq_bit   <= n_sq_bit;
        r_sl_mag   <= n_sl_mag;
        r_sl_neg   <= n_sl_neg;
        r_pend_neg <= n_pend_neg;
        r_off_neg  <= n_off_neg;
        r_lf       <= n_lf;
        r_rf       <= n_rf;
        r_out      <= n_out;
    end

    msru_div #(
        .DW (QW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dnd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    msru_mul #(
        .AW (QW),
        .BW (BW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `MSRU_ASSERT_ALWAYS(a_fill_range, i_clk, i_rst_n, r_fill != 2'd3)
    `MSRU_ASSERT_NEXT(a_frame_end_clears, i_clk, i_rst_n, in_acc && i_in_data.frame_end, r_fill == 2'd0)
    `MSRU_ASSERT_NEXT(a_full_window_works, i_clk, i_rst_n, in_acc && r_fill == 2'd2, r_state != S_IDLE)
    `MSRU_ASSERT_NEXT(a_done_waits, i_clk, i_rst_n, r_state == S_DONE && r_out_valid && !i_out_ready, r_state == S_DONE && $stable(r_out))

endmodule
